>>> design/acrl_pkg.sv
// Shared constants, widths and types of the alert cooldown rate limiter.
package acrl_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int TYPE_COUNT  = 64;
    localparam int AGENT_BITS  = 16;

    localparam int WINDOW_SECONDS = 60;

    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int TYPE_BITS = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
    localparam int KEY_W     = TYPE_BITS + AGENT_BITS;
    localparam int TIME_W    = 32;
    localparam int ENTRY_W   = KEY_W + TIME_W;

    localparam logic [15:0] AGENT_MASK = (AGENT_BITS >= 16) ? 16'hFFFF :
                                         16'((32'd1 << AGENT_BITS) - 32'd1);

    // verdict codes
    localparam logic [1:0] VERDICT_NOT_ROUTED = 2'd0;
    localparam logic [1:0] VERDICT_SUPPRESSED = 2'd1;
    localparam logic [1:0] VERDICT_DROPPED    = 2'd2;
    localparam logic [1:0] VERDICT_FIRED      = 2'd3;

    // result of the shared age unit
    typedef struct packed {
        logic signed [TIME_W-1:0] age;
        logic                     ge_thr;
        logic                     gt_best;
    } age_res_t;

endpackage

>>> design/acrl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module acrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/acrl_age_unit.sv
// Shared age unit: signed age of a time stamp, threshold and best-age compares.
module acrl_age_unit
    import acrl_pkg::*;
(
    input  logic [TIME_W-1:0]        now_time,
    input  logic [TIME_W-1:0]        then_time,
    input  logic [19:0]              thr,
    input  logic signed [TIME_W-1:0] best,
    output age_res_t                 res
);

    logic [TIME_W-1:0] diff;

    always_comb
    begin
        diff        = now_time - then_time;
        res.age     = $signed(diff);
        // compare in one extra bit so the unsigned threshold stays positive
        res.ge_thr  = $signed({diff[TIME_W-1], diff}) >=
                      $signed({{(TIME_W - 19){1'b0}}, thr});
        res.gt_best = $signed(diff) > best;
    end

endmodule

>>> design/alert_cooldown_rate_limiter_core.sv
// Top level of the alert cooldown rate limiter: sequencer, key table and APB registers.
//
// One event is taken at a time. An event whose type is not routed goes from the idle state
// straight to the output state. A routed event walks the whole key table through the
// single read port of the table RAM, one entry a cycle; after a hit it goes to the output
// state as suppressed, else the window state drops it on the budget or fires it through
// the insert state. A fire that finds the table at its limit walks the table a second time
// to sweep expired keys and find the oldest one, passing the evict state before the insert.
// From the output state the result is loaded once the output register is free, and the
// input is ready again in the cycle after that. All table walks share one age
// subtract-and-compare unit. Valid bits sit in flip-flops, so the block is ready
// straight after reset. A finished result waits in the output register while the next
// event is taken; the sequencer holds the following result until that register is free.
module alert_cooldown_rate_limiter_core
    import acrl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // event stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // type_id[5:0], agent_code[21:6], subject_tag[37:22],
                                       // now_time[69:38], zero fill
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // alert_type[5:0], alert_agent[21:6],
                                       // alert_subject[37:22], zero fill
    output logic [7:0]  m_axis_tuser   // verdict[1:0], evicted[2], zero fill
);

    localparam logic [1:0] REG_ROUTED   = 2'd0;
    localparam logic [1:0] REG_COOLDOWN = 2'd1;
    localparam logic [1:0] REG_FIRES    = 2'd2;
    localparam logic [1:0] REG_LIMIT    = 2'd3;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_WIN    = 3'd2;
    localparam logic [2:0] ST_SWEEP  = 3'd3;
    localparam logic [2:0] ST_EVICT  = 3'd4;
    localparam logic [2:0] ST_INSERT = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    localparam logic [IDX_W:0] SCAN_END = (IDX_W + 1)'(TABLE_DEPTH);

    // configuration
    logic [63:0] mask_reg;
    logic [19:0] cool_reg;
    logic [15:0] fires_reg;
    logic [6:0]  limit_reg;
    logic        cfg_wr;

    // sequencer
    logic [2:0]  state_reg, state_next;
    logic [IDX_W:0] scan_idx_reg, scan_idx_next;
    logic        pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic        hit_reg, hit_next;
    logic        match_vld_reg, match_vld_next;
    logic [IDX_W-1:0] match_idx_reg, match_idx_next;
    logic        free_vld_reg, free_vld_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic        found_reg, found_next;
    logic [IDX_W-1:0] victim_reg, victim_next;
    logic signed [TIME_W-1:0] best_reg, best_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [1:0]  verdict_reg, verdict_next;
    logic        evicted_reg, evicted_next;

    // table and window state
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [TIME_W-1:0] ws_reg, ws_next;
    logic [15:0] wc_reg, wc_next;

    // event payload
    logic [5:0]  type_reg;
    logic [15:0] agent_reg;
    logic [15:0] subject_reg;
    logic [TIME_W-1:0] now_reg;

    // result register
    logic        m_valid_reg, m_valid_next;
    logic        m_load;
    logic [1:0]  m_verdict_reg;
    logic        m_evicted_reg;
    logic [5:0]  m_type_reg;
    logic [15:0] m_agent_reg;
    logic [15:0] m_subject_reg;

    // datapath
    logic        s_accept;
    logic [5:0]  in_type;
    logic        in_routed;
    logic [KEY_W-1:0] key;
    logic        ram_we;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [KEY_W-1:0] rd_key;
    logic [TIME_W-1:0] rd_time;
    logic        ent_valid;
    logic        scan_issue;
    logic        scan_done;
    logic [TIME_W-1:0] au_then;
    logic [19:0] au_thr;
    age_res_t    au;
    logic [CNT_W-1:0] limit_eff;
    logic [31:0] lim32;
    logic [15:0] wc_eff;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            cool_reg  <= 20'd300;
            fires_reg <= 16'd60;
            limit_reg <= 7'd64;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:3])
                REG_ROUTED:   mask_reg  <= pwdata;
                REG_COOLDOWN: cool_reg  <= pwdata[19:0];
                REG_FIRES:    fires_reg <= pwdata[15:0];
                REG_LIMIT:    limit_reg <= pwdata[6:0];
                default:      mask_reg  <= mask_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:3])
            REG_ROUTED:   prdata = mask_reg;
            REG_COOLDOWN: prdata = {44'd0, cool_reg};
            REG_FIRES:    prdata = {48'd0, fires_reg};
            REG_LIMIT:    prdata = {57'd0, limit_reg};
            default:      prdata = '0;
        endcase
    end

    // limit of zero acts as one, above the depth as the depth
    always_comb
    begin
        lim32 = 32'(limit_reg);
        if (lim32 == 32'd0)
        begin
            lim32 = 32'd1;
        end
        else if (lim32 > 32'(TABLE_DEPTH))
        begin
            lim32 = 32'(TABLE_DEPTH);
        end
        limit_eff = CNT_W'(lim32);
    end

    // ---------------- input side ----------------
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign in_type       = s_axis_tdata[5:0];
    assign in_routed     = ({1'b0, in_type} < 7'(TYPE_COUNT)) && mask_reg[in_type];

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            type_reg    <= in_type;
            agent_reg   <= s_axis_tdata[21:6];
            subject_reg <= s_axis_tdata[37:22];
            now_reg     <= s_axis_tdata[69:38];
        end
    end

    assign key = (KEY_W'(type_reg[TYPE_BITS-1:0]) << AGENT_BITS) |
                 KEY_W'(agent_reg & AGENT_MASK);

    // ---------------- key table ----------------
    assign ram_raddr = scan_idx_reg[IDX_W-1:0];

    acrl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata ({now_reg, key}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key    = ram_rdata[KEY_W-1:0];
    assign rd_time   = ram_rdata[ENTRY_W-1:KEY_W];
    assign ent_valid = valid_reg[pend_idx_reg];

    assign au_then = (state_reg == ST_WIN) ? ws_reg : rd_time;
    assign au_thr  = (state_reg == ST_WIN) ? 20'(WINDOW_SECONDS) : cool_reg;

    acrl_age_unit u_age (
        .now_time  (now_reg),
        .then_time (au_then),
        .thr       (au_thr),
        .best      (best_reg),
        .res       (au)
    );

    assign scan_issue = (scan_idx_reg < SCAN_END);
    assign scan_done  = !scan_issue && !pend_reg;
    assign m_load     = (state_reg == ST_OUT) && (!m_valid_reg || m_axis_tready);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        hit_next       = hit_reg;
        match_vld_next = match_vld_reg;
        match_idx_next = match_idx_reg;
        free_vld_next  = free_vld_reg;
        free_idx_next  = free_idx_reg;
        found_next     = found_reg;
        victim_next    = victim_reg;
        best_next      = best_reg;
        slot_next      = slot_reg;
        verdict_next   = verdict_reg;
        evicted_next   = evicted_reg;
        valid_next     = valid_reg;
        fill_next      = fill_reg;
        ws_next        = ws_reg;
        wc_next        = wc_reg;
        wc_eff         = wc_reg;
        ram_we         = 1'b0;

        if ((state_reg == ST_SCAN || state_reg == ST_SWEEP) && scan_issue)
        begin
            scan_idx_next = scan_idx_reg + (IDX_W + 1)'(1);
            pend_next     = 1'b1;
            pend_idx_next = scan_idx_reg[IDX_W-1:0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    evicted_next   = 1'b0;
                    scan_idx_next  = '0;
                    hit_next       = 1'b0;
                    match_vld_next = 1'b0;
                    free_vld_next  = 1'b0;
                    if (in_routed)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        verdict_next = VERDICT_NOT_ROUTED;
                        state_next   = ST_OUT;
                    end
                end
            end

            ST_SCAN:
            begin
                if (pend_reg)
                begin
                    if (ent_valid)
                    begin
                        if (rd_key == key)
                        begin
                            if (!match_vld_reg)
                            begin
                                match_vld_next = 1'b1;
                                match_idx_next = pend_idx_reg;
                            end
                            if (!au.ge_thr)
                            begin
                                hit_next = 1'b1;
                            end
                        end
                    end
                    else if (!free_vld_reg)
                    begin
                        free_vld_next = 1'b1;
                        free_idx_next = pend_idx_reg;
                    end
                end
                if (scan_done)
                begin
                    if (hit_reg)
                    begin
                        verdict_next = VERDICT_SUPPRESSED;
                        state_next   = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_WIN;
                    end
                end
            end

            ST_WIN:
            begin
                // window rollover before the budget test
                if (au.ge_thr)
                begin
                    ws_next = now_reg;
                    wc_eff  = '0;
                end
                wc_next = wc_eff;
                if (wc_eff >= fires_reg)
                begin
                    verdict_next = VERDICT_DROPPED;
                    state_next   = ST_OUT;
                end
                else
                begin
                    wc_next = wc_eff + 16'd1;
                    if (fill_reg < limit_eff)
                    begin
                        slot_next  = match_vld_reg ? match_idx_reg : free_idx_reg;
                        state_next = ST_INSERT;
                    end
                    else
                    begin
                        scan_idx_next = '0;
                        free_vld_next = 1'b0;
                        found_next    = 1'b0;
                        best_next     = '0;
                        state_next    = ST_SWEEP;
                    end
                end
            end

            ST_SWEEP:
            begin
                if (pend_reg)
                begin
                    if (ent_valid && au.ge_thr)
                    begin
                        valid_next[pend_idx_reg] = 1'b0;
                        fill_next                = fill_reg - CNT_W'(1);
                        if (!free_vld_reg)
                        begin
                            free_vld_next = 1'b1;
                            free_idx_next = pend_idx_reg;
                        end
                    end
                    else if (ent_valid)
                    begin
                        // oldest survivor, ties to the lowest slot
                        if (!found_reg || au.gt_best)
                        begin
                            found_next  = 1'b1;
                            best_next   = au.age;
                            victim_next = pend_idx_reg;
                        end
                    end
                    else if (!free_vld_reg)
                    begin
                        free_vld_next = 1'b1;
                        free_idx_next = pend_idx_reg;
                    end
                end
                if (scan_done)
                begin
                    state_next = ST_EVICT;
                end
            end

            ST_EVICT:
            begin
                // the matching key, if any, was expired and has gone in the sweep
                if (fill_reg >= limit_eff && found_reg)
                begin
                    valid_next[victim_reg] = 1'b0;
                    fill_next              = fill_reg - CNT_W'(1);
                    evicted_next           = 1'b1;
                    if (free_vld_reg && free_idx_reg < victim_reg)
                    begin
                        slot_next = free_idx_reg;
                    end
                    else
                    begin
                        slot_next = victim_reg;
                    end
                end
                else
                begin
                    slot_next = free_idx_reg;
                end
                state_next = ST_INSERT;
            end

            ST_INSERT:
            begin
                ram_we               = 1'b1;
                valid_next[slot_reg] = 1'b1;
                if (!valid_reg[slot_reg])
                begin
                    fill_next = fill_reg + CNT_W'(1);
                end
                verdict_next = VERDICT_FIRED;
                state_next   = ST_OUT;
            end

            ST_OUT:
            begin
                if (m_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            valid_reg     <= '0;
            fill_reg      <= '0;
            ws_reg        <= '0;
            wc_reg        <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            pend_reg      <= pend_next;
            valid_reg     <= valid_next;
            fill_reg      <= fill_next;
            ws_reg        <= ws_next;
            wc_reg        <= wc_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg  <= pend_idx_next;
        hit_reg       <= hit_next;
        match_vld_reg <= match_vld_next;
        match_idx_reg <= match_idx_next;
        free_vld_reg  <= free_vld_next;
        free_idx_reg  <= free_idx_next;
        found_reg     <= found_next;
        victim_reg    <= victim_next;
        best_reg      <= best_next;
        slot_reg      <= slot_next;
        verdict_reg   <= verdict_next;
        evicted_reg   <= evicted_next;
    end

    // ---------------- result register ----------------
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (m_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_load)
        begin
            m_verdict_reg <= verdict_reg;
            m_evicted_reg <= evicted_reg;
            m_type_reg    <= type_reg;
            m_agent_reg   <= agent_reg;
            m_subject_reg <= subject_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'd0, m_subject_reg, m_agent_reg, m_type_reg};
    assign m_axis_tuser  = {5'd0, m_evicted_reg, m_verdict_reg};

endmodule

>>> design/acrl_checker.sv
// Port-level checks of the alert cooldown rate limiter, bound to the top level.
module acrl_checker
    import acrl_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pready,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [7:0]  m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // eviction is only reported on a fire
    a_evict_fire: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] != VERDICT_FIRED |-> !m_axis_tuser[2])
        else $error("eviction flagged without a fire");

    // one event at a time: not ready in the cycle after a transfer in
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second event taken straight after the first");

    // no result without an event: a result cannot appear in the cycle after a transfer in
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result appeared too early");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable |-> pready)
        else $error("configuration access stalled");

endmodule

bind alert_cooldown_rate_limiter_core acrl_checker u_acrl_checker (.*);

>>> bench/alert_cooldown_rate_limiter_core_test.sv
// Self-checking bench for the alert cooldown rate limiter: directed and random events.
module alert_cooldown_rate_limiter_core_test
    import acrl_pkg::*;
;

    localparam int REG_ROUTED_MASK = 0;
    localparam int REG_COOLDOWN    = 1;
    localparam int REG_BUDGET      = 2;
    localparam int REG_TABLE_LIMIT = 3;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 150;

    typedef struct packed {
        logic [5:0]  type_id;
        logic [15:0] agent;
        logic [15:0] subject;
        logic [31:0] stamp;
    } alert_event_t;

    typedef struct packed {
        logic [1:0]  verdict;
        logic        evicted;
        logic [5:0]  alert_type;
        logic [15:0] alert_agent;
        logic [15:0] alert_subject;
    } alert_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;  // type_id, agent_code, subject_tag, now_time, zero fill
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;       // alert_type, alert_agent, alert_subject, zero fill
    logic [7:0]  m_axis_tuser;       // verdict, evicted, zero fill

    // configuration as the block should hold it
    logic [63:0] routed_types = '0;
    logic [19:0] quiet_secs = 20'd300;
    logic [15:0] fire_budget = 16'd60;
    logic [6:0]  fill_cap = 7'd64;

    // key table and window as the block should hold them
    bit                 entry_live[TABLE_DEPTH];
    logic [KEY_W-1:0]   entry_key[TABLE_DEPTH];
    logic [31:0]        entry_stamp[TABLE_DEPTH];
    logic [31:0]        window_open = '0;
    logic [15:0]        window_fires = '0;

    alert_event_t  pending_events[$];
    alert_result_t awaited_alerts[$];

    bit          idle_on = 1'b1;
    bit          item_taken = 1'b0;
    int          send_gap = 0;
    int          take_gap = 0;
    int          items_queued = 0;
    int          items_accepted = 0;
    int          results_checked = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          settings_used = 0;
    int          verdict_tally[4];
    int          eviction_tally = 0;
    logic [31:0] clock_secs = '0;

    alert_cooldown_rate_limiter_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // signed difference of two stamps, modulo 2^32
    function automatic int stamp_age(logic [31:0] later, logic [31:0] earlier);
        return $signed(later - earlier);
    endfunction

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (entry_live[i])
                n++;
        end
        return n;
    endfunction

    function automatic alert_result_t judge_event(alert_event_t ev);
        alert_result_t    r;
        logic [KEY_W-1:0] key;
        bit               hit;
        int               hold;
        int               limit;
        int               slot;
        int               victim;
        int               oldest;
        int               age;
        hold = int'(quiet_secs);
        r.verdict = VERDICT_NOT_ROUTED;
        r.evicted = 1'b0;
        r.alert_type = ev.type_id;
        r.alert_agent = ev.agent;
        r.alert_subject = ev.subject;
        if (routed_types[ev.type_id])
        begin
            key = {ev.type_id, ev.agent};
            hit = 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (entry_live[i] && entry_key[i] == key &&
                    stamp_age(ev.stamp, entry_stamp[i]) < hold)
                    hit = 1'b1;
            end
            if (hit)
                r.verdict = VERDICT_SUPPRESSED;
            else
            begin
                if (stamp_age(ev.stamp, window_open) >= WINDOW_SECONDS)
                begin
                    window_open = ev.stamp;
                    window_fires = '0;
                end
                if (window_fires >= fire_budget)
                    r.verdict = VERDICT_DROPPED;
                else
                begin
                    window_fires++;
                    limit = (fill_cap == 0) ? 1 :
                            (fill_cap > TABLE_DEPTH) ? TABLE_DEPTH : int'(fill_cap);
                    if (live_count() >= limit)
                    begin
                        // sweep expired keys, then evict the oldest if still full
                        for (int i = 0; i < TABLE_DEPTH; i++)
                        begin
                            if (entry_live[i] && stamp_age(ev.stamp, entry_stamp[i]) >= hold)
                                entry_live[i] = 1'b0;
                        end
                        if (live_count() >= limit)
                        begin
                            victim = -1;
                            oldest = 0;
                            for (int i = 0; i < TABLE_DEPTH; i++)
                            begin
                                if (entry_live[i])
                                begin
                                    age = stamp_age(ev.stamp, entry_stamp[i]);
                                    if (victim < 0 || age > oldest)
                                    begin
                                        victim = i;
                                        oldest = age;
                                    end
                                end
                            end
                            entry_live[victim] = 1'b0;
                            r.evicted = 1'b1;
                        end
                    end
                    slot = -1;
                    for (int i = 0; i < TABLE_DEPTH; i++)
                    begin
                        if (slot < 0 && entry_live[i] && entry_key[i] == key)
                            slot = i;
                    end
                    for (int i = 0; i < TABLE_DEPTH; i++)
                    begin
                        if (slot < 0 && !entry_live[i])
                            slot = i;
                    end
                    entry_live[slot] = 1'b1;
                    entry_key[slot] = key;
                    entry_stamp[slot] = ev.stamp;
                    r.verdict = VERDICT_FIRED;
                end
            end
        end
        return r;
    endfunction

    // event sender
    always @(negedge clk)
    begin : feed
        alert_event_t ev;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || item_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                send_gap = $urandom_range(0, 3);
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_events.size() > 0)
            begin
                ev = pending_events.pop_front();
                s_axis_tdata <= {2'b00, ev.stamp, ev.subject, ev.agent, ev.type_id};
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (take_gap > 0)
        begin
            take_gap--;
            m_axis_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            take_gap = $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // transfer monitor, checker and watchdog
    always @(posedge clk)
    begin : observe
        alert_event_t  ev;
        alert_result_t got;
        alert_result_t want;
        bit            moved;
        moved = 1'b0;
        item_taken = rst_n && s_axis_tvalid && s_axis_tready;
        if (item_taken)
        begin
            ev.type_id = s_axis_tdata[5:0];
            ev.agent = s_axis_tdata[21:6];
            ev.subject = s_axis_tdata[37:22];
            ev.stamp = s_axis_tdata[69:38];
            want = judge_event(ev);
            verdict_tally[want.verdict]++;
            if (want.evicted)
                eviction_tally++;
            awaited_alerts.push_back(want);
            items_accepted++;
            moved = 1'b1;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            moved = 1'b1;
            got = {m_axis_tuser[1:0], m_axis_tuser[2], m_axis_tdata[5:0],
                   m_axis_tdata[21:6], m_axis_tdata[37:22]};
            if (awaited_alerts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing outstanding: verdict %0d type %0d agent %h",
                             got.verdict, got.alert_type, got.alert_agent);
            end
            else
            begin
                want = awaited_alerts.pop_front();
                results_checked++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch on result %0d: verdict %0d/%0d evicted %0d/%0d ",
                                  "type %0d/%0d agent %h/%h subject %h/%h (expected/actual)"},
                                 results_checked, want.verdict, got.verdict,
                                 want.evicted, got.evicted, want.alert_type, got.alert_type,
                                 want.alert_agent, got.alert_agent,
                                 want.alert_subject, got.alert_subject);
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic offer(input logic [5:0] type_id, input logic [15:0] agent,
                         input logic [15:0] subject, input logic [31:0] stamp);
        pending_events.push_back({type_id, agent, subject, stamp});
        items_queued++;
    endtask

    // hold the sender until every expected result is back
    task automatic wait_drain();
        while (items_accepted != items_queued || results_checked != items_accepted)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input int index, input logic [63:0] value);
        logic [63:0] rd_want;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(index * 8);
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        rd_want = '0;
        case (index)
            REG_ROUTED_MASK:
            begin
                routed_types = value;
                rd_want = value;
            end
            REG_COOLDOWN:
            begin
                quiet_secs = value[19:0];
                rd_want = {44'd0, value[19:0]};
            end
            REG_BUDGET:
            begin
                fire_budget = value[15:0];
                rd_want = {48'd0, value[15:0]};
            end
            REG_TABLE_LIMIT:
            begin
                fill_cap = value[6:0];
                rd_want = {57'd0, value[6:0]};
            end
            default: ;
        endcase
        // the address still points at the register just written
        if (!pready || prdata !== rd_want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("register %0d reads %h, expected %h", index, prdata, rd_want);
        end
    endtask

    task automatic set_config(input logic [63:0] mask, input logic [19:0] cooldown,
                              input logic [15:0] budget, input logic [6:0] limit);
        wait_drain();
        write_reg(REG_ROUTED_MASK, mask);
        write_reg(REG_COOLDOWN, 64'(cooldown));
        write_reg(REG_BUDGET, 64'(budget));
        write_reg(REG_TABLE_LIMIT, 64'(limit));
        settings_used++;
    endtask

    // random events over a small pool of keys so that cooldown and eviction get hit;
    // nagents of zero means every agent is fresh
    task automatic queue_random(input int count, input int ntypes, input int nagents,
                                input int step_max, input bit jumps);
        logic [5:0]  type_pool[8];
        logic [15:0] agent_pool[8];
        logic [5:0]  t;
        logic [5:0]  pick_type;
        logic [15:0] pick_agent;
        int          tries;
        for (int i = 0; i < 8; i++)
        begin
            t = 6'($urandom);
            tries = 0;
            while (!routed_types[t] && tries < 64)
            begin
                t = 6'($urandom);
                tries++;
            end
            type_pool[i] = t;
            agent_pool[i] = 16'($urandom);
        end
        for (int n = 0; n < count; n++)
        begin
            case (jumps ? $urandom_range(0, 39) : 39)
                0: clock_secs = $urandom;
                1: clock_secs = clock_secs - $urandom_range(1, 200);
                2: clock_secs = 32'hFFFF_FFFF - $urandom_range(0, 100);
                default: clock_secs = clock_secs + $urandom_range(0, step_max);
            endcase
            pick_type = ($urandom_range(0, 7) == 0) ? 6'($urandom)
                                                    : type_pool[$urandom_range(0, ntypes - 1)];
            pick_agent = (nagents == 0) ? 16'($urandom)
                                        : agent_pool[$urandom_range(0, nagents - 1)];
            offer(pick_type, pick_agent, 16'($urandom), clock_secs);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings route nothing
        offer(6'd0, 16'h0000, 16'h0000, 32'h0000_0000);
        offer(6'd63, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);

        // directed: cooldown edge, budget exhaustion, eviction, backwards time, wrap
        set_config(64'h7FFF_FFFF_FFFF_FFFF, 20'd10, 16'd3, 7'd2);
        offer(6'd63, 16'hFFFF, 16'hFFFF, 32'd0);
        offer(6'd0, 16'h0000, 16'h0000, 32'd100);
        offer(6'd0, 16'h0000, 16'h0001, 32'd105);
        offer(6'd0, 16'h0000, 16'h0002, 32'd110);
        offer(6'd1, 16'hFFFF, 16'h0003, 32'd111);
        offer(6'd2, 16'h0001, 16'h0004, 32'd112);
        offer(6'd2, 16'h0001, 16'h0005, 32'd160);
        offer(6'd3, 16'h0002, 16'h0006, 32'd161);
        offer(6'd4, 16'h0003, 16'h0007, 32'd162);
        offer(6'd5, 16'h0004, 16'h0008, 32'd163);
        offer(6'd2, 16'h0001, 16'h0009, 32'd100);
        offer(6'd6, 16'h0005, 16'hAAAA, 32'hFFFF_FFF0);
        offer(6'd6, 16'h0005, 16'h5555, 32'h0000_0010);
        offer(6'd62, 16'hAAAA, 16'h0000, 32'h8000_0000);
        offer(6'd0, 16'h0000, 16'hFFFF, 32'h7FFF_FFFF);
        offer(6'd61, 16'h5555, 16'h1234, 32'hFFFF_FFFF);
        clock_secs = 32'd1000;

        set_config({$urandom, $urandom}, 20'd30, 16'd5, 7'd3);
        queue_random(80, 3, 4, 6, 1'b1);

        // zero cooldown and a limit of zero, treated as one
        set_config({64{1'b1}}, 20'd0, 16'hFFFF, 7'd0);
        queue_random(60, 4, 4, 3, 1'b1);

        // fill the whole table and keep evicting
        set_config({64{1'b1}}, 20'hFFFFF, 16'hFFFF, 7'd64);
        queue_random(120, 8, 0, 2, 1'b0);

        // no budget at all, limit beyond the table depth
        set_config({$urandom, $urandom}, 20'd50, 16'd0, 7'd127);
        queue_random(40, 3, 3, 10, 1'b1);

        // limit lowered well below the current fill
        set_config({$urandom, $urandom}, 20'd100, 16'd2, 7'd2);
        queue_random(100, 4, 6, 15, 1'b1);

        set_config({$urandom, $urandom}, 20'd20, 16'd10, 7'd5);
        idle_on = 1'b0;
        queue_random(80, 3, 4, 4, 1'b1);

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Checked %0d events over %0d register settings, idling on both sides",
                 results_checked, settings_used + 1);
        $display("Outcomes: %0d fired, %0d suppressed, %0d dropped, %0d not routed, %0d evictions",
                 verdict_tally[VERDICT_FIRED], verdict_tally[VERDICT_SUPPRESSED],
                 verdict_tally[VERDICT_DROPPED], verdict_tally[VERDICT_NOT_ROUTED],
                 eviction_tally);
        if (mismatches == 0 && awaited_alerts.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
